/* hw/rtl/ghbs_pkg.sv */
// ----------------------------------------------------------------------------
// ghbs_pkg
// Shared types and constants of the heading-grid Bellman sweep block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghbs_pkg;

  localparam logic [2:0] MODE_LOAD_VALUE = 3'd0;
  localparam logic [2:0] MODE_LOAD_PEN   = 3'd1;
  localparam logic [2:0] MODE_LOAD_MOVE  = 3'd2;
  localparam logic [2:0] MODE_SWEEP      = 3'd3;
  localparam logic [2:0] MODE_READ       = 3'd4;

  localparam logic [7:0] PEN_GOAL     = 8'd254;
  localparam logic [7:0] PEN_OBSTACLE = 8'd255;
  localparam int         TURN_STEP    = 3;

  localparam logic       KIND_READ  = 1'b0;
  localparam logic       KIND_SWEEP = 1'b1;

  localparam logic       REG_TILE_WIDTH  = 1'b0;
  localparam logic       REG_TILE_HEIGHT = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [5:0]  hd;
    logic [1:0]  act;
    logic [15:0] value;
    logic [7:0]  pen;
    logic [7:0]  mv;
    logic        ok;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic [15:0] max_change;
  } res_t;

endpackage

/* hw/rtl/ghbs_front.sv */
// ----------------------------------------------------------------------------
// ghbs_front
// Accepts transactions, decodes mode and range checks, queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghbs_front import ghbs_pkg::*; #(
  parameter int BUF_HEIGHT = 32,
  parameter int BUF_WIDTH  = 32,
  parameter int HEADINGS   = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_col,
  input  logic [5:0]  in_heading,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_value_in,
  input  logic [7:0]  in_penalty_in,
  input  logic signed [3:0] in_move_dx,
  input  logic signed [3:0] in_move_dy,
  input  logic        deq,
  output logic        head_valid,
  output cmd_t        head
);

  cmd_t             q_r [QDEPTH];
  logic [QPW-1:0]   wp_r, rp_r;
  logic [QPW:0]     cnt_r;
  cmd_t             cmd;
  logic             known;
  logic             enq;
  logic             cell_ok, hd_ok;

  assign cell_ok = (int'(in_row) < BUF_HEIGHT) && (int'(in_col) < BUF_WIDTH);
  assign hd_ok   = int'(in_heading) < HEADINGS;

  always_comb begin
    cmd.op    = in_mode;
    cmd.row   = in_row;
    cmd.col   = in_col;
    cmd.hd    = in_heading;
    cmd.act   = in_action;
    cmd.value = in_value_in;
    cmd.pen   = in_penalty_in;
    cmd.mv    = {in_move_dy, in_move_dx};
    cmd.ok    = 1'b0;
    known     = 1'b1;
    unique case (in_mode)
      MODE_LOAD_VALUE, MODE_READ: cmd.ok = cell_ok && hd_ok;
      MODE_LOAD_PEN:              cmd.ok = cell_ok;
      MODE_LOAD_MOVE:             cmd.ok = hd_ok;
      MODE_SWEEP:                 cmd.ok = 1'b1;
      default:                    known  = 1'b0;
    endcase
  end

  assign in_full    = (cnt_r == (QPW+1)'(QDEPTH));
  assign enq        = in_push && !in_full && known;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (enq) wp_r <= wp_r + 1'b1;
      if (deq) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPW+1)'(enq) - (QPW+1)'(deq);
    end
  end

endmodule

/* hw/rtl/ghbs_back.sv */
// ----------------------------------------------------------------------------
// ghbs_back
// Executes commands: table loads, value reads and the in-place sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghbs_back import ghbs_pkg::*; #(
  parameter int BUF_HEIGHT = 32,
  parameter int BUF_WIDTH  = 32,
  parameter int HEADINGS   = 60,
  parameter int HALO_CELLS = 2,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        deq,
  input  logic [4:0]  tile_w,
  input  logic [4:0]  tile_h,
  output logic        res_empty,
  input  logic        res_pop,
  output res_t        res
);

  localparam int VDEPTH = BUF_HEIGHT * BUF_WIDTH * HEADINGS;
  localparam int PDEPTH = BUF_HEIGHT * BUF_WIDTH;
  localparam int MDEPTH = 4 * HEADINGS;
  localparam int VA = $clog2(VDEPTH);
  localparam int PA = $clog2(PDEPTH);
  localparam int MA = $clog2(MDEPTH);
  localparam int HW = $clog2(HEADINGS);
  localparam int VB = VALUE_BITS;
  localparam int RCAP = BUF_HEIGHT - HALO_CELLS;
  localparam int CCAP = BUF_WIDTH - HALO_CELLS;
  localparam logic [VB-1:0] INF = '1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_CELL  = 4'd3;
  localparam logic [3:0] S_CELLW = 4'd4;
  localparam logic [3:0] S_MV    = 4'd5;
  localparam logic [3:0] S_ADDR  = 4'd6;
  localparam logic [3:0] S_COST  = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [2:0] K_OLD   = 3'd0;
  localparam logic [2:0] K_FWD   = 3'd1;
  localparam logic [2:0] K_BWD   = 3'd2;
  localparam logic [2:0] K_TL    = 3'd3;
  localparam logic [2:0] K_TR    = 3'd4;
  localparam logic [2:0] K_FL    = 3'd5;
  localparam logic [2:0] K_FR    = 3'd6;

  logic [VB-1:0] vmem [VDEPTH];
  logic [7:0]    pmem [PDEPTH];
  logic [7:0]    mmem [MDEPTH];

  logic [3:0]    state_r;
  logic [4:0]    iy_r, ix_r;
  logic [HW-1:0] h_r;
  logic [2:0]    k_r;
  logic          use_move_r, inb_r, rd_ok_r;
  logic [4:0]    rd_row_r, rd_col_r;
  logic [5:0]    rd_hd_r;
  logic [VB-1:0] old_r, min_r, best_r, vq;
  logic [7:0]    pq, mq;

  res_t          oq_r [2];
  logic          owp_r, orp_r;
  logic [1:0]    ocnt_r;
  logic          opush;
  res_t          ores;

  logic [4:0]    rows, cols;
  logic          last_cell;
  logic [HW-1:0] hl, hr, th;
  logic [1:0]    mact;
  int            by, bx, nr, nc;
  logic          inb;
  logic [VB-1:0] cost, diff;
  logic [VB:0]   sum;
  logic          load_v, load_p, load_m, start;

  logic          v_we;
  logic [VA-1:0] v_waddr, v_raddr;
  logic [VB-1:0] v_wdata;
  logic [PA-1:0] p_addr, p_raddr;
  logic [MA-1:0] m_waddr, m_raddr;

  function automatic logic [VA-1:0] vaddr(int r, int c, int h);
    return VA'((r * BUF_WIDTH + c) * HEADINGS + h);
  endfunction

  function automatic logic [PA-1:0] paddr(int r, int c);
    return PA'(r * BUF_WIDTH + c);
  endfunction

  assign rows = (int'(tile_h) > RCAP) ? 5'(RCAP) : tile_h;
  assign cols = (int'(tile_w) > CCAP) ? 5'(CCAP) : tile_w;
  assign last_cell = (ix_r == cols - 5'd1) && (iy_r == rows - 5'd1);

  assign hl = (int'(h_r) + TURN_STEP >= HEADINGS) ?
              HW'(int'(h_r) + TURN_STEP - HEADINGS) : HW'(int'(h_r) + TURN_STEP);
  assign hr = (int'(h_r) < TURN_STEP) ?
              HW'(int'(h_r) + HEADINGS - TURN_STEP) : HW'(int'(h_r) - TURN_STEP);

  always_comb begin
    th   = h_r;
    mact = 2'd0;
    case (k_r)
      K_BWD:       mact = 2'd1;
      K_TL:        th = hl;
      K_TR:        th = hr;
      K_FL: begin
        th   = hl;
        mact = 2'd2;
      end
      K_FR: begin
        th   = hr;
        mact = 2'd3;
      end
      default:     th = h_r;
    endcase
  end

  assign by  = int'(iy_r) + HALO_CELLS;
  assign bx  = int'(ix_r) + HALO_CELLS;
  assign nr  = by + (use_move_r ? int'($signed(mq[7:4])) : 0);
  assign nc  = bx + (use_move_r ? int'($signed(mq[3:0])) : 0);
  assign inb = (nr >= 0) && (nr < BUF_HEIGHT) && (nc >= 0) && (nc < BUF_WIDTH);

  always_comb begin
    sum = {1'b0, vq} + (VB+1)'((pq == PEN_GOAL) ? 8'd0 : pq);
    if (!inb_r || vq == INF || pq == PEN_OBSTACLE) begin
      cost = INF;
    end else if (sum >= {1'b0, INF}) begin
      cost = INF - 1'b1;
    end else begin
      cost = sum[VB-1:0];
    end
    diff = (min_r > old_r) ? min_r - old_r : old_r - min_r;
  end

  assign load_v = (state_r == S_IDLE) && head_valid && head.op == MODE_LOAD_VALUE;
  assign load_p = (state_r == S_IDLE) && head_valid && head.op == MODE_LOAD_PEN;
  assign load_m = (state_r == S_IDLE) && head_valid && head.op == MODE_LOAD_MOVE;
  assign start  = (state_r == S_IDLE) && head_valid && ocnt_r != 2'd2 &&
                  (head.op == MODE_SWEEP || head.op == MODE_READ);
  assign deq    = load_v || load_p || load_m || start;

  assign v_we    = (load_v && head.ok) || state_r == S_WR;
  assign v_waddr = load_v ? vaddr(int'(head.row), int'(head.col), int'(head.hd))
                          : vaddr(by, bx, int'(h_r));
  assign v_wdata = load_v ? VB'(head.value) : min_r;
  assign v_raddr = (state_r == S_RD) ? vaddr(int'(rd_row_r), int'(rd_col_r), int'(rd_hd_r))
                                     : vaddr(nr, nc, int'(th));
  assign p_addr  = paddr(int'(head.row), int'(head.col));
  assign p_raddr = (state_r == S_CELL) ? paddr(by, bx) : paddr(nr, nc);
  assign m_waddr = MA'(int'(head.act) * HEADINGS + int'(head.hd));
  assign m_raddr = MA'(int'(mact) * HEADINGS + int'(h_r));

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vq <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_p && head.ok) pmem[p_addr] <= head.pen;
    pq <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_m && head.ok) mmem[m_waddr] <= head.mv;
    mq <= mmem[m_raddr];
  end

  always_comb begin
    opush = 1'b0;
    ores  = '0;
    if (state_r == S_RDW) begin
      opush      = 1'b1;
      ores.kind  = KIND_READ;
      ores.value = rd_ok_r ? 16'(vq) : 16'd0;
    end else if (state_r == S_DONE) begin
      opush           = 1'b1;
      ores.kind       = KIND_SWEEP;
      ores.max_change = 16'(best_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      rd_row_r <= head.row;
      rd_col_r <= head.col;
      rd_hd_r  <= head.hd;
      rd_ok_r  <= head.ok;
    end
    if (state_r == S_ADDR) inb_r <= inb;
    if (opush) oq_r[owp_r] <= ores;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      iy_r       <= '0;
      ix_r       <= '0;
      h_r        <= '0;
      k_r        <= K_OLD;
      use_move_r <= 1'b0;
      old_r      <= '0;
      min_r      <= '0;
      best_r     <= '0;
      owp_r      <= 1'b0;
      orp_r      <= 1'b0;
      ocnt_r     <= '0;
    end else begin
      if (opush) owp_r <= ~owp_r;
      if (res_pop && ocnt_r != 2'd0) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(opush) - 2'(res_pop && ocnt_r != 2'd0);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (head.op == MODE_READ) begin
              state_r <= S_RD;
            end else begin
              iy_r   <= '0;
              ix_r   <= '0;
              best_r <= '0;
              state_r <= (rows == 5'd0 || cols == 5'd0) ? S_DONE : S_CELL;
            end
          end
        end
        S_RD:    state_r <= S_RDW;
        S_RDW:   state_r <= S_IDLE;
        S_CELL:  state_r <= S_CELLW;
        S_CELLW: begin
          h_r <= '0;
          k_r <= K_OLD;
          if (pq < PEN_GOAL) begin
            state_r <= S_MV;
          end else if (last_cell) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_CELL;
            if (ix_r == cols - 5'd1) begin
              ix_r <= '0;
              iy_r <= iy_r + 5'd1;
            end else begin
              ix_r <= ix_r + 5'd1;
            end
          end
        end
        S_MV: begin
          use_move_r <= (k_r == K_FWD || k_r == K_BWD || k_r == K_FL || k_r == K_FR);
          state_r    <= S_ADDR;
        end
        S_ADDR:  state_r <= S_COST;
        S_COST: begin
          if (k_r == K_OLD) begin
            old_r <= vq;
            min_r <= INF;
          end else if (cost < min_r) begin
            min_r <= cost;
          end
          if (k_r == K_FR) begin
            state_r <= S_WR;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_MV;
          end
        end
        S_WR: begin
          if (diff > best_r) best_r <= diff;
          k_r <= K_OLD;
          if (int'(h_r) != HEADINGS - 1) begin
            h_r     <= h_r + 1'b1;
            state_r <= S_MV;
          end else if (last_cell) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_CELL;
            if (ix_r == cols - 5'd1) begin
              ix_r <= '0;
              iy_r <= iy_r + 5'd1;
            end else begin
              ix_r <= ix_r + 5'd1;
            end
          end
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_empty = (ocnt_r == 2'd0);
  assign res       = oq_r[orp_r];

endmodule

/* hw/rtl/grid_heading_bellman_sweep.sv */
// ----------------------------------------------------------------------------
// grid_heading_bellman_sweep
// In-place value-iteration sweep over a haloed grid with a heading axis.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  input    | in_push / in_full  | mode, row, col, heading, action, value, penalty, move
//  result   | out_pop / out_empty| kind, value_out, max_change
//  config   | cfg_we             | cfg_index, cfg_wdata (tile_width, tile_height)
//
//  A sweep visits rows*cols cells and runs HEADINGS headings for each cell that
//  is not a goal or an obstacle: a heading runs seven value reads (move-table
//  read, address, cost) and one write-back. Reset is synchronous; memories are
//  not cleared.
//  A four-entry command queue and a two-entry result queue decouple the sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_heading_bellman_sweep import ghbs_pkg::*; #(
  parameter int BUF_HEIGHT = 32,
  parameter int BUF_WIDTH  = 32,
  parameter int HEADINGS   = 60,
  parameter int HALO_CELLS = 2,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_col,
  input  logic [5:0]  in_heading,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_value_in,
  input  logic [7:0]  in_penalty_in,
  input  logic signed [3:0] in_move_dx,
  input  logic signed [3:0] in_move_dy,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [15:0] out_value_out,
  output logic [15:0] out_max_change,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  logic       head_valid, deq;
  cmd_t       head;
  res_t       res;
  logic [4:0] tile_w_r, tile_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_w_r <= 5'd28;
      tile_h_r <= 5'd28;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:  tile_w_r <= cfg_wdata;
        REG_TILE_HEIGHT: tile_h_r <= cfg_wdata;
        default:         tile_w_r <= tile_w_r;
      endcase
    end
  end

  ghbs_front #(
    .BUF_HEIGHT(BUF_HEIGHT), .BUF_WIDTH(BUF_WIDTH), .HEADINGS(HEADINGS)
  ) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_mode, .in_row, .in_col, .in_heading,
    .in_action, .in_value_in, .in_penalty_in, .in_move_dx, .in_move_dy,
    .deq, .head_valid, .head
  );

  ghbs_back #(
    .BUF_HEIGHT(BUF_HEIGHT), .BUF_WIDTH(BUF_WIDTH), .HEADINGS(HEADINGS),
    .HALO_CELLS(HALO_CELLS), .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk, .rst_n, .head_valid, .head, .deq, .tile_w(tile_w_r), .tile_h(tile_h_r),
    .res_empty(out_empty), .res_pop(out_pop), .res
  );

  assign out_kind       = res.kind;
  assign out_value_out  = res.value;
  assign out_max_change = res.max_change;

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_read_no_max: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_READ) |-> out_max_change == 16'd0)
    else $error("read answer carries a max change");

  a_sweep_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_SWEEP) |-> out_value_out == 16'd0)
    else $error("sweep result carries a value");

endmodule

/* tb/sv/grid_heading_bellman_sweep_tb.sv */
// ----------------------------------------------------------------------------
// grid_heading_bellman_sweep_tb
// Self-checking bench for the heading-grid Bellman sweep: loads a small working
// strip and the move table, then runs directed corner cases, capped tile sweeps
// and random load/read/sweep traffic against an in-bench cost-grid predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_heading_bellman_sweep_tb;
  import ghbs_pkg::*;

  localparam int ROWS = 32;
  localparam int COLS = 32;
  localparam int HDS  = 60;
  localparam logic [15:0] INF = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [2:0]  in_mode = '0;
  logic [4:0]  in_row = '0;
  logic [4:0]  in_col = '0;
  logic [5:0]  in_heading = '0;
  logic [1:0]  in_action = '0;
  logic [15:0] in_value_in = '0;
  logic [7:0]  in_penalty_in = '0;
  logic signed [3:0] in_move_dx = '0;
  logic signed [3:0] in_move_dy = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_kind;
  logic [15:0] out_value_out;
  logic [15:0] out_max_change;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  grid_heading_bellman_sweep dut (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [15:0] cost_grid [ROWS][COLS][HDS];
  logic [7:0]  pen_grid [ROWS][COLS];
  logic [7:0]  move_tab [4][HDS];
  logic [4:0]  tile_w = 5'd28;
  logic [4:0]  tile_h = 5'd28;

  res_t pending_results[$];
  int   errors = 0;
  int   n_items = 0, n_reads = 0, n_sweeps = 0, n_checked = 0;
  bit   steady = 1'b0;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic [15:0] step_cost(int r, int c, int h);
    logic [16:0] s;
    logic [7:0]  p;
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return INF;
    p = pen_grid[r][c];
    if (cost_grid[r][c][h] == INF || p == PEN_OBSTACLE) return INF;
    if (p == PEN_GOAL) p = '0;
    s = {1'b0, cost_grid[r][c][h]} + {9'd0, p};
    return (s >= {1'b0, INF}) ? INF - 16'd1 : s[15:0];
  endfunction

  function automatic logic [15:0] moved_cost(int r, int c, int h, int a, int th);
    logic [7:0] m;
    int dx, dy;
    m  = move_tab[a][h];
    dx = int'($signed(m[3:0]));
    dy = int'($signed(m[7:4]));
    return step_cost(r + dy, c + dx, th);
  endfunction

  function automatic logic [15:0] bellman_sweep();
    logic [15:0] best, oldv, m, c;
    int rows, cols, by, bx, hl, hr;
    best = '0;
    rows = (int'(tile_h) > ROWS - 2) ? ROWS - 2 : int'(tile_h);
    cols = (int'(tile_w) > COLS - 2) ? COLS - 2 : int'(tile_w);
    for (int iy = 0; iy < rows; iy++)
      for (int ix = 0; ix < cols; ix++) begin
        by = iy + 2;
        bx = ix + 2;
        if (pen_grid[by][bx] >= PEN_GOAL) continue;
        for (int h = 0; h < HDS; h++) begin
          hl = (h + TURN_STEP) % HDS;
          hr = (h - TURN_STEP + HDS) % HDS;
          oldv = cost_grid[by][bx][h];
          m = moved_cost(by, bx, h, 0, h);
          c = moved_cost(by, bx, h, 1, h);  if (c < m) m = c;
          c = step_cost(by, bx, hl);        if (c < m) m = c;
          c = step_cost(by, bx, hr);        if (c < m) m = c;
          c = moved_cost(by, bx, h, 2, hl); if (c < m) m = c;
          c = moved_cost(by, bx, h, 3, hr); if (c < m) m = c;
          cost_grid[by][bx][h] = m;
          c = (m > oldv) ? m - oldv : oldv - m;
          if (c > best) best = c;
        end
      end
    return best;
  endfunction

  function automatic void predict(logic [2:0] mode, logic [4:0] r, logic [4:0] c,
                                  logic [5:0] h, logic [1:0] a, logic [15:0] v,
                                  logic [7:0] p, logic [3:0] dx, logic [3:0] dy);
    res_t e;
    case (mode)
      MODE_LOAD_VALUE: if (h < HDS) cost_grid[r][c][h] = v;
      MODE_LOAD_PEN:   pen_grid[r][c] = p;
      MODE_LOAD_MOVE:  if (h < HDS) move_tab[a][h] = {dy, dx};
      MODE_SWEEP: begin
        e.kind = KIND_SWEEP; e.value = '0; e.max_change = bellman_sweep();
        pending_results.push_back(e);
        n_sweeps++;
      end
      MODE_READ: begin
        e.kind = KIND_READ; e.max_change = '0;
        e.value = (h < HDS) ? cost_grid[r][c][h] : '0;
        pending_results.push_back(e);
        n_reads++;
      end
      default: ;
    endcase
  endfunction

  task automatic push_item(logic [2:0] mode, logic [4:0] r, logic [4:0] c, logic [5:0] h,
                           logic [1:0] a, logic [15:0] v, logic [7:0] p,
                           logic [3:0] dx, logic [3:0] dy);
    if (!steady && $urandom_range(99) < 29) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_mode <= mode; in_row <= r; in_col <= c; in_heading <= h; in_action <= a;
    in_value_in <= v; in_penalty_in <= p; in_move_dx <= dx; in_move_dy <= dy;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict(mode, r, c, h, a, v, p, dx, dy);
    n_items++;
  endtask

  task automatic load_value(int r, int c, int h, logic [15:0] v);
    push_item(MODE_LOAD_VALUE, 5'(r), 5'(c), 6'(h), 2'($urandom), v, 8'($urandom),
              4'($urandom), 4'($urandom));
  endtask

  task automatic load_pen(int r, int c, logic [7:0] p);
    push_item(MODE_LOAD_PEN, 5'(r), 5'(c), 6'($urandom), 2'($urandom), 16'($urandom), p,
              4'($urandom), 4'($urandom));
  endtask

  task automatic load_move(int a, int h, logic [3:0] dx, logic [3:0] dy);
    push_item(MODE_LOAD_MOVE, 5'($urandom), 5'($urandom), 6'(h), 2'(a), 16'($urandom),
              8'($urandom), dx, dy);
  endtask

  task automatic read_value(int r, int c, int h);
    push_item(MODE_READ, 5'(r), 5'(c), 6'(h), 2'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom), 4'($urandom));
  endtask

  task automatic sweep();
    push_item(MODE_SWEEP, 5'($urandom), 5'($urandom), 6'($urandom), 2'($urandom),
              16'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
  endtask

  // loads give no result, so allow the command queue to drain after the last one
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_tile(logic [4:0] w, logic [4:0] h);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= REG_TILE_WIDTH; cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_TILE_HEIGHT; cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tile_w = w;
    tile_h = h;
  endtask

  function automatic logic [7:0] rand_pen();
    int k;
    k = $urandom_range(99);
    if (k < 8) return PEN_OBSTACLE;
    if (k < 14) return PEN_GOAL;
    return 8'($urandom_range(253));
  endfunction

  function automatic logic [7:0] rand_skip_pen();
    return ($urandom_range(1) == 0) ? PEN_OBSTACLE : PEN_GOAL;
  endfunction

  function automatic logic [15:0] rand_value();
    int k;
    k = $urandom_range(99);
    if (k < 10) return INF;
    if (k < 15) return 16'($urandom);
    if (k < 20) return 16'($urandom_range(65534, 65400));
    return 16'($urandom_range(2000));
  endfunction

  // moves stay on row 2 between columns 1 and 4, or leave the buffer
  function automatic logic [3:0] rand_dx();
    int k;
    k = $urandom_range(3);
    if (k == 0) return 4'hF;
    if (k == 1) return 4'h0;
    if (k == 2) return 4'h1;
    return 4'h8;
  endfunction

  function automatic logic [3:0] rand_dy();
    return ($urandom_range(4) == 0) ? 4'h8 : 4'h0;
  endfunction

  // result side
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 16'(out_kind), 16'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_kind != e.kind) report_mismatch("kind", 16'(out_kind), 16'(e.kind));
        if (out_value_out != e.value) report_mismatch("value_out", out_value_out, e.value);
        if (out_max_change != e.max_change)
          report_mismatch("max_change", out_max_change, e.max_change);
      end
    end
    out_pop <= steady || ($urandom_range(99) >= 29);
  end

  task automatic test_fill();
    for (int c = 1; c < 5; c++) begin
      load_pen(2, c, rand_pen());
      for (int h = 0; h < HDS; h++) load_value(2, c, h, rand_value());
    end
    for (int a = 0; a < 4; a++)
      for (int h = 0; h < HDS; h++)
        load_move(a, h, rand_dx(), rand_dy());
  endtask

  task automatic test_directed();
    load_value(2, 2, 0, 16'd0);
    load_value(2, 4, 59, INF);
    load_value(5, 5, 63, 16'h1234);
    read_value(2, 2, 0);
    read_value(2, 4, 59);
    read_value(5, 5, 63);
    read_value(31, 31, 60);
    push_item(3'd5, 5'd2, 5'd2, 6'd0, 2'd0, 16'hFFFF, 8'hFF, 4'hF, 4'hF);
    push_item(3'd6, 5'd31, 5'd31, 6'd63, 2'd3, 16'h0, 8'h0, 4'h0, 4'h0);
    push_item(3'd7, 5'd0, 5'd0, 6'd0, 2'd0, 16'hAAAA, 8'h55, 4'h8, 4'h7);
    load_move(0, 0, 4'h8, 4'h0);
    load_move(3, 59, 4'hF, 4'h0);
    load_move(1, 63, 4'h1, 4'h1);
    load_pen(2, 2, 8'd0);
    load_pen(2, 3, PEN_GOAL);
    load_pen(2, 1, PEN_OBSTACLE);
    load_value(2, 2, 3, 16'hFFFE);
    set_tile(5'd1, 5'd1);
    sweep();
    read_value(2, 2, 0);
    set_tile(5'd0, 5'd1);
    sweep();
    set_tile(5'd2, 5'd0);
    sweep();
    load_pen(2, 3, 8'd1);
    set_tile(5'd2, 5'd1);
    sweep();
    read_value(2, 3, 1);
  endtask

  // tiles past the cap; every extra cell is a goal or an obstacle
  task automatic test_big_tile();
    load_pen(2, 4, PEN_OBSTACLE);
    for (int c = 5; c < COLS; c++) load_pen(2, c, rand_skip_pen());
    load_pen(2, 2, 8'd7);
    load_pen(2, 3, 8'd0);
    set_tile(5'd31, 5'd1);
    sweep();
    read_value(2, 3, $urandom_range(59));
    for (int r = 3; r < ROWS; r++) load_pen(r, 2, rand_skip_pen());
    set_tile(5'd1, 5'd31);
    sweep();
    set_tile(5'd1, 5'd30);
    sweep();
    read_value(2, 2, $urandom_range(59));
  endtask

  task automatic test_random();
    int k, c;
    for (int i = 0; i < 230; i++) begin
      steady = (i >= 90 && i < 150);
      if (i % 40 == 0)
        set_tile(($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(1, 2)),
                 ($urandom_range(9) == 0) ? 5'd0 : 5'd1);
      c = $urandom_range(1, 4);
      k = $urandom_range(99);
      if (k < 30) begin
        if ($urandom_range(9) == 0)
          load_value($urandom_range(31), $urandom_range(31), $urandom_range(63), rand_value());
        else
          load_value(2, c, $urandom_range(63), rand_value());
      end
      else if (k < 42) load_pen(2, c, rand_pen());
      else if (k < 52) load_move($urandom_range(3), $urandom_range(63), rand_dx(), rand_dy());
      else if (k < 58) sweep();
      else if (k < 94) begin
        if ($urandom_range(9) == 0)
          read_value($urandom_range(31), $urandom_range(31), $urandom_range(63, 60));
        else
          read_value(2, c, $urandom_range(59));
      end
      else push_item(3'($urandom_range(5, 7)), 5'($urandom), 5'($urandom), 6'($urandom),
                     2'($urandom), 16'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill();
    test_directed();
    test_big_tile();
    test_random();
    wait_drained();
    $display("Sent %0d items: %0d reads and %0d sweeps, %0d result transactions checked.",
             n_items, n_reads, n_sweeps, n_checked);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still expected", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
